// ===== rtl/core/swsr_pkg.sv =====
// ----------------------------------------------------------------------------
// swsr_pkg
// Shared types and constants for the single wire sensor reader.
// ----------------------------------------------------------------------------
package swsr_pkg;

  localparam int TIMEOUT_WIDTH  = 20;
  localparam int CFG_ADDR_WIDTH = 5;
  localparam int CFG_DATA_WIDTH = 32;
  localparam int IN_DATA_WIDTH  = 8;
  localparam int OUT_DATA_WIDTH = 16;

  // register indexes
  localparam logic [2:0] REG_START_LOW    = 3'd0;
  localparam logic [2:0] REG_START_HIGH   = 3'd1;
  localparam logic [2:0] REG_RESP_FIRST   = 3'd2;
  localparam logic [2:0] REG_RESP_SECOND  = 3'd3;
  localparam logic [2:0] REG_BIT_SAMPLE   = 3'd4;
  localparam logic [2:0] REG_LEVEL_TMO    = 3'd5;
  localparam logic [2:0] REG_BYTES_FRAME  = 3'd6;

  // register reset values
  localparam logic [15:0]              RST_START_LOW   = 16'd1000;
  localparam logic [7:0]               RST_START_HIGH  = 8'd20;
  localparam logic [7:0]               RST_RESP_FIRST  = 8'd40;
  localparam logic [7:0]               RST_RESP_SECOND = 8'd80;
  localparam logic [7:0]               RST_BIT_SAMPLE  = 8'd40;
  localparam logic [TIMEOUT_WIDTH-1:0] RST_LEVEL_TMO   = TIMEOUT_WIDTH'(100000);
  localparam logic [3:0]               RST_BYTES_FRAME = 4'd5;

  localparam logic [2:0] BITS_PER_BYTE_LAST = 3'd7;

  // line drive codes
  localparam logic [1:0] DRIVE_RELEASED = 2'd0;
  localparam logic [1:0] DRIVE_LOW      = 2'd1;
  localparam logic [1:0] DRIVE_HIGH     = 2'd2;

  // response codes
  localparam logic [1:0] RESP_HIGH_FIRST = 2'd0;
  localparam logic [1:0] RESP_LOW_HIGH   = 2'd1;
  localparam logic [1:0] RESP_STUCK_LOW  = 2'd2;

  typedef struct packed {
    logic [15:0]              start_low_ticks;
    logic [7:0]               start_high_ticks;
    logic [7:0]               response_first_ticks;
    logic [7:0]               response_second_ticks;
    logic [7:0]               bit_sample_ticks;
    logic [TIMEOUT_WIDTH-1:0] level_timeout_ticks;
    logic [3:0]               bytes_per_frame;
  } swsr_cfg_t;

  typedef struct packed {
    logic       busy_res;
    logic       error;
    logic       response_valid;
    logic [1:0] response_code;
    logic       last_byte;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [1:0] drive_mode;
  } swsr_result_t;

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

// ===== rtl/core/swsr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// swsr_cfg_regs
// APB register bank holding the timing and frame settings.
// ----------------------------------------------------------------------------
module swsr_cfg_regs
  import swsr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_DATA_WIDTH-1:0] pwdata,
  output logic [CFG_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  output swsr_cfg_t                 cfg
);

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_low_ticks       <= RST_START_LOW;
      cfg.start_high_ticks      <= RST_START_HIGH;
      cfg.response_first_ticks  <= RST_RESP_FIRST;
      cfg.response_second_ticks <= RST_RESP_SECOND;
      cfg.bit_sample_ticks      <= RST_BIT_SAMPLE;
      cfg.level_timeout_ticks   <= RST_LEVEL_TMO;
      cfg.bytes_per_frame       <= RST_BYTES_FRAME;
    end else if (wr_en) begin
      case (reg_index)
        REG_START_LOW:   cfg.start_low_ticks       <= pwdata[15:0];
        REG_START_HIGH:  cfg.start_high_ticks      <= pwdata[7:0];
        REG_RESP_FIRST:  cfg.response_first_ticks  <= pwdata[7:0];
        REG_RESP_SECOND: cfg.response_second_ticks <= pwdata[7:0];
        REG_BIT_SAMPLE:  cfg.bit_sample_ticks      <= pwdata[7:0];
        REG_LEVEL_TMO:   cfg.level_timeout_ticks   <= pwdata[TIMEOUT_WIDTH-1:0];
        REG_BYTES_FRAME: cfg.bytes_per_frame       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_START_LOW:   prdata = CFG_DATA_WIDTH'(cfg.start_low_ticks);
      REG_START_HIGH:  prdata = CFG_DATA_WIDTH'(cfg.start_high_ticks);
      REG_RESP_FIRST:  prdata = CFG_DATA_WIDTH'(cfg.response_first_ticks);
      REG_RESP_SECOND: prdata = CFG_DATA_WIDTH'(cfg.response_second_ticks);
      REG_BIT_SAMPLE:  prdata = CFG_DATA_WIDTH'(cfg.bit_sample_ticks);
      REG_LEVEL_TMO:   prdata = CFG_DATA_WIDTH'(cfg.level_timeout_ticks);
      REG_BYTES_FRAME: prdata = CFG_DATA_WIDTH'(cfg.bytes_per_frame);
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/swsr_seq.sv =====
// ----------------------------------------------------------------------------
// swsr_seq
// Conversion sequencer: start pulse, response sampling, bit and byte capture,
// level timeouts. Advances one state step per accepted tick.
// ----------------------------------------------------------------------------
module swsr_seq
  import swsr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic         line_level,
  input  logic         start_req,
  input  swsr_cfg_t    cfg,
  output swsr_result_t result
);

  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_LOW      = 9'b000000010,
    PH_HIGH     = 9'b000000100,
    PH_RESP1    = 9'b000001000,
    PH_RESP2    = 9'b000010000,
    PH_RESP_END = 9'b000100000,
    PH_RISE     = 9'b001000000,
    PH_BIT      = 9'b010000000,
    PH_FALL     = 9'b100000000
  } phase_t;

  phase_t                   phase, phase_next;
  logic [15:0]              delay_count, delay_count_next;
  logic [TIMEOUT_WIDTH-1:0] wait_count, wait_count_next;
  logic [2:0]               bit_index, bit_index_next;
  logic [7:0]               shift_byte, shift_byte_next;
  logic [3:0]               bytes_done, bytes_done_next;
  logic [1:0]               response_held, response_held_next;

  logic [15:0]              delay_inc;
  logic [TIMEOUT_WIDTH-1:0] wait_inc;
  logic [TIMEOUT_WIDTH-1:0] timeout_target;
  logic                     wait_expired;
  logic [3:0]               bytes_inc;
  logic [3:0]               frame_target;
  logic [7:0]               data;
  logic                     bvalid, last, rvalid, err;

  assign delay_inc      = delay_count + 16'd1;
  assign wait_inc       = wait_count + TIMEOUT_WIDTH'(1);
  assign timeout_target = (cfg.level_timeout_ticks == '0) ? TIMEOUT_WIDTH'(1)
                                                          : cfg.level_timeout_ticks;
  assign wait_expired   = wait_inc >= timeout_target;
  assign bytes_inc      = bytes_done + 4'd1;
  assign frame_target   = (cfg.bytes_per_frame == 4'd0) ? 4'd1 : cfg.bytes_per_frame;

  always_comb begin
    phase_next         = phase;
    delay_count_next   = delay_count;
    wait_count_next    = wait_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    bytes_done_next    = bytes_done;
    response_held_next = response_held;
    data   = 8'd0;
    bvalid = 1'b0;
    last   = 1'b0;
    rvalid = 1'b0;
    err    = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (start_req) begin
          phase_next         = PH_LOW;
          delay_count_next   = 16'd1;
          bit_index_next     = 3'd0;
          shift_byte_next    = 8'd0;
          bytes_done_next    = 4'd0;
          response_held_next = RESP_HIGH_FIRST;
        end
      end
      PH_LOW: begin
        if (delay_count >= at_least_one(cfg.start_low_ticks)) begin
          if (cfg.start_high_ticks != 8'd0) begin
            phase_next       = PH_HIGH;
            delay_count_next = 16'd1;
          end else begin
            phase_next       = PH_RESP1;
            delay_count_next = 16'd0;
          end
        end else begin
          delay_count_next = delay_inc;
        end
      end
      PH_HIGH: begin
        if (delay_count >= {8'd0, cfg.start_high_ticks}) begin
          phase_next       = PH_RESP1;
          delay_count_next = 16'd0;
        end else begin
          delay_count_next = delay_inc;
        end
      end
      PH_RESP1: begin
        delay_count_next = delay_inc;
        if (delay_inc >= at_least_one({8'd0, cfg.response_first_ticks})) begin
          if (line_level) begin
            response_held_next = RESP_HIGH_FIRST;
            rvalid             = 1'b1;
            phase_next         = PH_RESP_END;
            wait_count_next    = '0;
          end else begin
            phase_next       = PH_RESP2;
            delay_count_next = 16'd0;
          end
        end
      end
      PH_RESP2: begin
        delay_count_next = delay_inc;
        if (delay_inc >= at_least_one({8'd0, cfg.response_second_ticks})) begin
          response_held_next = line_level ? RESP_LOW_HIGH : RESP_STUCK_LOW;
          rvalid             = 1'b1;
          phase_next         = PH_RESP_END;
          wait_count_next    = '0;
        end
      end
      PH_RESP_END: begin
        if (!line_level) begin
          phase_next      = PH_RISE;
          wait_count_next = '0;
        end else begin
          wait_count_next = wait_inc;
          if (wait_expired) begin
            err        = 1'b1;
            phase_next = PH_IDLE;
          end
        end
      end
      PH_RISE: begin
        if (line_level) begin
          phase_next       = PH_BIT;
          delay_count_next = 16'd0;
        end else begin
          wait_count_next = wait_inc;
          if (wait_expired) begin
            err        = 1'b1;
            phase_next = PH_IDLE;
          end
        end
      end
      PH_BIT: begin
        delay_count_next = delay_inc;
        if (delay_inc >= at_least_one({8'd0, cfg.bit_sample_ticks})) begin
          shift_byte_next = {shift_byte[6:0], line_level};
          phase_next      = PH_FALL;
          wait_count_next = '0;
        end
      end
      PH_FALL: begin
        if (!line_level) begin
          wait_count_next = '0;
          if (bit_index == BITS_PER_BYTE_LAST) begin
            data            = shift_byte;
            bvalid          = 1'b1;
            bytes_done_next = bytes_inc;
            bit_index_next  = 3'd0;
            shift_byte_next = 8'd0;
            if (bytes_inc >= frame_target) begin
              last       = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_RISE;
            end
          end else begin
            bit_index_next = bit_index + 3'd1;
            phase_next     = PH_RISE;
          end
        end else begin
          wait_count_next = wait_inc;
          if (wait_expired) begin
            err        = 1'b1;
            phase_next = PH_IDLE;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      delay_count   <= 16'd0;
      wait_count    <= '0;
      bit_index     <= 3'd0;
      shift_byte    <= 8'd0;
      bytes_done    <= 4'd0;
      response_held <= RESP_HIGH_FIRST;
    end else if (advance) begin
      phase         <= phase_next;
      delay_count   <= delay_count_next;
      wait_count    <= wait_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      bytes_done    <= bytes_done_next;
      response_held <= response_held_next;
    end
  end

  always_comb begin
    result.drive_mode     = (phase_next == PH_LOW)  ? DRIVE_LOW :
                            (phase_next == PH_HIGH) ? DRIVE_HIGH : DRIVE_RELEASED;
    result.data_byte      = data;
    result.byte_valid     = bvalid;
    result.last_byte      = last;
    result.response_code  = response_held_next;
    result.response_valid = rvalid;
    result.error          = err;
    result.busy_res       = (phase_next != PH_IDLE);
  end

endmodule

// ===== rtl/core/single_wire_sensor_reader_unit.sv =====
// output: a result leaves on m_tdata the cycle after its tick request is taken
// throughput: one tick request per cycle unless a result waits on m_tready;
// sequencer state steps once per tick; the result register decouples output
// reset: synchronous, active high; sequencer idle, counters clear, registers at
// their default timing values, no result pending
// ----------------------------------------------------------------------------
// single_wire_sensor_reader_unit
// Single wire sensor line reader: start pulse, response code and data bytes.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader_unit
  import swsr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // apb configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_DATA_WIDTH-1:0] pwdata,
  output logic [CFG_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  // tick requests
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_DATA_WIDTH-1:0]  s_tdata,  // line_level, start_req, zero fill
  // results
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // drive_mode[1:0], data_byte[9:2], byte_valid, response_code[12:11],
  // response_valid, error, busy_res
  output logic [OUT_DATA_WIDTH-1:0] m_tdata,
  output logic                      m_tlast   // last_byte
);

  swsr_cfg_t    cfg;
  swsr_result_t result;
  swsr_result_t out_q;
  logic         accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  swsr_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swsr_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .advance    (accept),
    .line_level (s_tdata[0]),
    .start_req  (s_tdata[1]),
    .cfg        (cfg),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign m_tdata = {out_q.busy_res, out_q.error, out_q.response_valid,
                    out_q.response_code, out_q.byte_valid, out_q.data_byte,
                    out_q.drive_mode};
  assign m_tlast = out_q.last_byte;

  a_err_no_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_q.error && (out_q.byte_valid || out_q.response_valid)))
    else $error("error reported together with data");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_q.last_byte) |-> (out_q.byte_valid && !out_q.busy_res))
    else $error("last byte without end of frame");

  a_error_idles: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_q.error) |-> (!out_q.busy_res &&
                                   out_q.drive_mode == DRIVE_RELEASED))
    else $error("error while still busy");

  a_drive_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_q.drive_mode == DRIVE_RELEASED ||
                  out_q.drive_mode == DRIVE_LOW || out_q.drive_mode == DRIVE_HIGH))
    else $error("bad drive code");

endmodule
